// ----- design/pti_pkg.sv -----
// Package for the permittivity table interpolator: tables, fixed-point conversion and codes.
package pti_pkg;

	localparam int ENTRIES = 49;
	localparam int IDX_W = $clog2(ENTRIES);

	localparam int X_W = 16;
	localparam int Y_W = 18;
	localparam int OUT_W = 24;
	localparam int DVD_W = 36;
	localparam int CNT_W = $clog2(DVD_W);
	localparam int SUM_W = DVD_W + 2;

	localparam logic [2:0] MAT_GOLD = 3'd4;
	localparam logic [2:0] MAT_COPPER = 3'd1;
	localparam logic [2:0] MAT_RESET = MAT_GOLD;

	localparam logic [0:0] REG_MATERIAL = 1'b0;

	typedef int tab_int_t [ENTRIES];
	typedef logic [X_W-1:0] bp_arr_t [ENTRIES];
	typedef logic signed [Y_W-1:0] val_arr_t [ENTRIES];

	localparam tab_int_t BP_TENTHS = '{
		1879, 1916, 1953, 1993, 2033, 2073, 2119, 2164, 2214, 2262, 2313, 2371, 2426, 2490,
		2551, 2616, 2689, 2761, 2844, 2924, 3009, 3107, 3204, 3315, 3425, 3542, 3679, 3815,
		3974, 4133, 4305, 4509, 4714, 4959, 5209, 5486, 5821, 6168, 6595, 7045, 7560, 8211,
		8920, 9840, 10880, 12160, 13930, 16100, 19370};

	localparam tab_int_t GOLD_RE = '{
		2271, 2952, 2925, 2039, 1382, -104, -1325, -2338, -3463, -4155, -5510, -6169,
		-7445, -8913, -10804, -12365, -13464, -13665, -13323, -13068, -12274, -12425,
		-12308, -13553, -13102, -12320, -14006, -16049, -16494, -17022, -16922, -17590,
		-17027, -22783, -39462, -58421, -81127, -106619, -136482, -168177, -206102,
		-258113, -320407, -402741, -510496, -662185, -904265, -1253500, -1890420};

	localparam tab_int_t GOLD_IM = '{
		-30413, -31759, -32857, -33277, -33968, -33904, -35100, -36062, -37102, -38252,
		-38922, -40550, -41633, -43385, -44901, -47223, -49763, -52824, -54949, -55964,
		-57803, -57926, -58458, -55737, -55382, -55980, -56092, -56444, -57389, -57174,
		-56492, -52826, -48444, -38126, -25804, -21113, -16605, -13742, -10352, -10668,
		-12718, -16266, -19254, -27940, -38610, -57015, -81863, -125552, -253552};

	localparam tab_int_t COPPER_RE = '{
		-9040, -10240, -11327, -12686, -14224, -15367, -16442, -17202, -17403, -17334,
		-16984, -16088, -14408, -13022, -10430, -8714, -6797, -5777, -5642, -6503, -8590,
		-10850, -12747, -15204, -16249, -17942, -20510, -24131, -27351, -32324, -37505,
		-42080, -46028, -50857, -54093, -56005, -68216, -101820, -139916, -176379,
		-217046, -267648, -331798, -411268, -519555, -677496, -887347, -1230770,
		-1791770};

	localparam tab_int_t COPPER_IM = '{
		-25136, -26372, -27936, -29263, -30690, -32300, -34341, -36698, -39256, -41725,
		-44083, -46131, -48213, -48854, -49096, -47686, -48372, -48063, -47357, -46377,
		-47012, -47720, -49211, -48803, -50701, -52498, -53720, -54397, -55862, -56499,
		-57625, -59446, -62075, -62562, -61549, -52571, -37856, -19230, -16487, -17661,
		-22392, -26936, -34608, -41094, -51962, -79152, -113268, -169024, -292774};

	// tenths of nm to Q.4, round half up: floor((8t+2)/5) by reciprocal
	function automatic logic [X_W-1:0] conv_bp(int t);
		longint m;
		m = longint'(t) * 64'sd8 + 64'sd2;
		return X_W'((m * 64'sd209716) >>> 20);
	endfunction

	// 1e-4 units to Q.8, round half away from zero: (16|v|+312)/625 by reciprocal
	function automatic logic signed [Y_W-1:0] conv_val(int v);
		longint a;
		longint q;
		a = (v < 0) ? -longint'(v) : longint'(v);
		a = a * 64'sd16 + 64'sd312;
		q = (a * 64'sd109951163) >>> 36;
		return (v < 0) ? Y_W'(-q) : Y_W'(q);
	endfunction

	function automatic bp_arr_t build_bp(tab_int_t src);
		bp_arr_t r;
		for (int k = 0; k < ENTRIES; k++) begin
			r[k] = conv_bp(src[k]);
		end
		return r;
	endfunction

	function automatic val_arr_t build_val(tab_int_t src);
		val_arr_t r;
		for (int k = 0; k < ENTRIES; k++) begin
			r[k] = conv_val(src[k]);
		end
		return r;
	endfunction

	localparam bp_arr_t BP_Q4 = build_bp(BP_TENTHS);
	localparam val_arr_t GOLD_RE_Q8 = build_val(GOLD_RE);
	localparam val_arr_t GOLD_IM_Q8 = build_val(GOLD_IM);
	localparam val_arr_t COPPER_RE_Q8 = build_val(COPPER_RE);
	localparam val_arr_t COPPER_IM_Q8 = build_val(COPPER_IM);

	localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(8388607);
	localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(8388608);

endpackage

// ----- design/permittivity_table_interpolator.sv -----
// Top level of the permittivity table interpolator: search, multiply, serial divide, clip.
//
// One wavelength (Q.4 nm) enters on the s_ channel; one complex permittivity (Q.8) leaves
// on the m_ channel. The APB port holds material_code at address 0 (4 gold, 1 copper);
// any other code returns zeros with bad_material set in m_tuser.
// A transaction is taken only while s_tready is high, one item at a time. The breakpoint
// search compares one table entry per cycle, and a load step forms the offset and interval
// width; then for the real part and then the imaginary part come a multiply step, a setup
// step, the bit-serial restoring divider and an add/clip step, before the output step. Both
// parts share the one divider. An unsupported material code goes straight to the output step.
// The result sits in an output register; if m_tready is low, the block holds it and waits
// in its final state until the register is free, and s_tready stays low meanwhile.
// Reset clears m_tvalid, returns the sequencer to idle and sets material_code to 4.
module permittivity_table_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] wavelength
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [23:0] eps_real, [47:24] eps_imag
	output logic [1:0]  m_tuser,   // [0] bad_material, [1] saturated
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEARCH, ST_LOAD, ST_MUL, ST_PREP, ST_DIV, ST_ADD, ST_FIN
	} state_t;

	state_t state_q;
	logic [2:0] material_q;
	logic [pti_pkg::X_W-1:0] x_q;
	logic [pti_pkg::IDX_W-1:0] idx_q;
	logic [pti_pkg::IDX_W-1:0] lo_q;
	logic signed [pti_pkg::X_W:0] dx_q;
	logic [pti_pkg::X_W-1:0] den_q;
	logic comp_q;
	logic signed [pti_pkg::DVD_W-1:0] prod_q;
	logic neg_q;
	logic [pti_pkg::DVD_W-1:0] dvd_q;
	logic [pti_pkg::X_W-1:0] rem_q;
	logic [pti_pkg::CNT_W-1:0] cnt_q;
	logic [pti_pkg::OUT_W-1:0] res_re_q;
	logic [pti_pkg::OUT_W-1:0] res_im_q;
	logic sat_q;
	logic bad_q;
	logic m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic cfg_wr;
	logic supported;
	logic bp_lt;
	logic [pti_pkg::IDX_W-1:0] lo_d;
	logic signed [pti_pkg::Y_W-1:0] y0;
	logic signed [pti_pkg::Y_W-1:0] y1;
	logic signed [pti_pkg::Y_W:0] dy;
	logic [pti_pkg::DVD_W-1:0] mag;
	logic [pti_pkg::X_W:0] trial;
	logic trial_ge;
	logic [pti_pkg::DVD_W-1:0] quot;
	logic signed [pti_pkg::SUM_W-1:0] ysum;
	logic [pti_pkg::OUT_W-1:0] yclip;
	logic yclipped;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr == pti_pkg::REG_MATERIAL) ? {29'd0, material_q} : 32'd0;

	assign supported = (material_q == pti_pkg::MAT_GOLD) || (material_q == pti_pkg::MAT_COPPER);
	assign bp_lt = pti_pkg::BP_Q4[idx_q] < x_q;
	assign lo_d = (idx_q == '0) ? '0 : idx_q - 1'b1;

	always_comb begin
		if (material_q == pti_pkg::MAT_GOLD) begin
			y0 = comp_q ? pti_pkg::GOLD_IM_Q8[lo_q] : pti_pkg::GOLD_RE_Q8[lo_q];
			y1 = comp_q ? pti_pkg::GOLD_IM_Q8[lo_q + 1'b1] : pti_pkg::GOLD_RE_Q8[lo_q + 1'b1];
		end else begin
			y0 = comp_q ? pti_pkg::COPPER_IM_Q8[lo_q] : pti_pkg::COPPER_RE_Q8[lo_q];
			y1 = comp_q ? pti_pkg::COPPER_IM_Q8[lo_q + 1'b1]
				: pti_pkg::COPPER_RE_Q8[lo_q + 1'b1];
		end
	end

	assign dy = {y1[pti_pkg::Y_W-1], y1} - {y0[pti_pkg::Y_W-1], y0};
	assign mag = prod_q[pti_pkg::DVD_W-1] ? pti_pkg::DVD_W'(-prod_q) : pti_pkg::DVD_W'(prod_q);

	assign trial = {rem_q, dvd_q[pti_pkg::DVD_W-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	assign quot = (den_q == '0) ? '0 : dvd_q;

	always_comb begin
		ysum = {{(pti_pkg::SUM_W - pti_pkg::Y_W){y0[pti_pkg::Y_W-1]}}, y0};
		if (neg_q) begin
			ysum = ysum - signed'({2'b00, quot});
		end else begin
			ysum = ysum + signed'({2'b00, quot});
		end
		if (ysum > pti_pkg::OUT_MAX) begin
			yclip = pti_pkg::OUT_MAX[pti_pkg::OUT_W-1:0];
			yclipped = 1'b1;
		end else if (ysum < pti_pkg::OUT_MIN) begin
			yclip = pti_pkg::OUT_MIN[pti_pkg::OUT_W-1:0];
			yclipped = 1'b1;
		end else begin
			yclip = ysum[pti_pkg::OUT_W-1:0];
			yclipped = 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			material_q <= pti_pkg::MAT_RESET;
			m_tvalid_q <= 1'b0;
			comp_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_wr && paddr == pti_pkg::REG_MATERIAL) begin
				material_q <= pwdata[2:0];
			end
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q <= s_tdata;
						idx_q <= '0;
						comp_q <= 1'b0;
						res_re_q <= '0;
						res_im_q <= '0;
						sat_q <= 1'b0;
						bad_q <= !supported;
						state_q <= supported ? ST_SEARCH : ST_FIN;
					end
				end
				ST_SEARCH: begin
					if (bp_lt && idx_q != pti_pkg::IDX_W'(pti_pkg::ENTRIES - 1)) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						lo_q <= lo_d;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					dx_q <= signed'({1'b0, x_q}) - signed'({1'b0, pti_pkg::BP_Q4[lo_q]});
					den_q <= pti_pkg::BP_Q4[lo_q + 1'b1] - pti_pkg::BP_Q4[lo_q];
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= dy * dx_q;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					neg_q <= prod_q[pti_pkg::DVD_W-1];
					dvd_q <= mag + pti_pkg::DVD_W'(den_q[pti_pkg::X_W-1:1]);
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= trial_ge ? pti_pkg::X_W'(trial - {1'b0, den_q})
						: trial[pti_pkg::X_W-1:0];
					dvd_q <= {dvd_q[pti_pkg::DVD_W-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pti_pkg::CNT_W'(pti_pkg::DVD_W - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					sat_q <= sat_q | yclipped;
					if (comp_q) begin
						res_im_q <= yclip;
						state_q <= ST_FIN;
					end else begin
						res_re_q <= yclip;
						comp_q <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {res_im_q, res_re_q};
						m_tuser_q <= {sat_q, bad_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- test/tb_permittivity_table_interpolator.sv -----
// Testbench for permittivity_table_interpolator: directed and random wavelengths vs a predictor.
module tb_permittivity_table_interpolator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES = 200;
	localparam int MAX_SHOWN = 10;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct {
		logic [15:0] wl;
		logic [23:0] re;
		logic [23:0] im;
		logic        bad;
		logic        sat;
	} eps_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] wavelength
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // [23:0] eps_real, [47:24] eps_imag
	logic [1:0]  m_tuser;        // [0] bad_material, [1] saturated
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [0:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	eps_t        eps_expected [$];
	eps_t        want;
	logic [2:0]  material_q = pti_pkg::MAT_GOLD;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_request = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          bad_seen = 0;
	int          sat_seen = 0;

	permittivity_table_interpolator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	function automatic longint div_half_away(input longint num, input longint den);
		longint n;
		longint d;
		longint q;
		if (den == 0) begin
			return 0;
		end
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = (n + d / 2) / d;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint breakpoint_q4(input int k);
		return div_half_away(longint'(pti_pkg::BP_TENTHS[k]) * 8, 5);
	endfunction

	function automatic longint lerp_q8(input longint x, input int lo,
			input pti_pkg::tab_int_t col);
		longint x0;
		longint x1;
		longint y0;
		longint y1;
		x0 = breakpoint_q4(lo);
		x1 = breakpoint_q4(lo + 1);
		y0 = div_half_away(longint'(col[lo]) * 16, 625);
		y1 = div_half_away(longint'(col[lo + 1]) * 16, 625);
		return y0 + div_half_away((y1 - y0) * (x - x0), x1 - x0);
	endfunction

	function automatic logic [23:0] clip24(input longint v, output logic hit);
		hit = 1'b0;
		if (v > 64'sd8388607) begin
			v = 64'sd8388607;
			hit = 1'b1;
		end
		if (v < -64'sd8388608) begin
			v = -64'sd8388608;
			hit = 1'b1;
		end
		return v[23:0];
	endfunction

	function automatic eps_t predict_eps(input logic [15:0] wl, input logic [2:0] mat);
		eps_t   r;
		int     i;
		int     lo;
		longint x;
		logic   hit_re;
		logic   hit_im;
		r.wl = wl;
		r.re = '0;
		r.im = '0;
		r.sat = 1'b0;
		r.bad = 1'b0;
		if (mat != pti_pkg::MAT_GOLD && mat != pti_pkg::MAT_COPPER) begin
			r.bad = 1'b1;
			return r;
		end
		x = longint'(wl);
		i = 0;
		while (i < pti_pkg::ENTRIES && breakpoint_q4(i) < x) i++;
		if (i >= pti_pkg::ENTRIES) i = pti_pkg::ENTRIES - 1;
		lo = i - 1;
		if (lo < 0) lo = 0;
		if (lo > pti_pkg::ENTRIES - 2) lo = pti_pkg::ENTRIES - 2;
		if (mat == pti_pkg::MAT_GOLD) begin
			r.re = clip24(lerp_q8(x, lo, pti_pkg::GOLD_RE), hit_re);
			r.im = clip24(lerp_q8(x, lo, pti_pkg::GOLD_IM), hit_im);
		end else begin
			r.re = clip24(lerp_q8(x, lo, pti_pkg::COPPER_RE), hit_re);
			r.im = clip24(lerp_q8(x, lo, pti_pkg::COPPER_IM), hit_im);
		end
		r.sat = hit_re | hit_im;
		return r;
	endfunction

	function automatic logic [15:0] pick_wavelength();
		int c;
		int k;
		int bp_first;
		int bp_last;
		bp_first = int'(breakpoint_q4(0));
		bp_last = int'(breakpoint_q4(pti_pkg::ENTRIES - 1));
		c = $urandom_range(99);
		if (c < 40) begin
			return 16'($urandom_range(bp_last, bp_first));
		end else if (c < 60) begin
			k = $urandom_range(pti_pkg::ENTRIES - 1);
			return 16'(int'(breakpoint_q4(k)) + int'($urandom_range(6)) - 3);
		end else if (c < 70) begin
			return 16'($urandom_range(bp_first));
		end else if (c < 85) begin
			return 16'($urandom_range(65535, bp_last));
		end
		return 16'($urandom);
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] wl,
			input longint exp_v, input longint got_v);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("MISMATCH %s at wavelength %0d: expected %0d, got %0d",
				field, wl, exp_v, got_v);
		end
	endtask

	task automatic send_wavelength(input logic [15:0] wl);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= wl;
		do @(posedge clk); while (!s_tready);
		eps_expected.push_back(predict_eps(wl, material_q));
		items_sent++;
	endtask

	task automatic wait_results_idle();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
		end
		while (eps_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_material(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pti_pkg::REG_MATERIAL;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		material_q = value[2:0];
	endtask

	task automatic test_directed_points();
		logic [15:0] gold_pts [11];
		logic [15:0] copper_pts [5];
		gold_pts = '{16'd0, 16'd1, 16'(breakpoint_q4(0) - 1), 16'(breakpoint_q4(0)),
			16'(breakpoint_q4(0) + 1), 16'(breakpoint_q4(1)), 16'(breakpoint_q4(24) + 7),
			16'(breakpoint_q4(pti_pkg::ENTRIES - 1) - 1),
			16'(breakpoint_q4(pti_pkg::ENTRIES - 1)),
			16'(breakpoint_q4(pti_pkg::ENTRIES - 1) + 1), 16'hFFFF};
		copper_pts = '{16'd0, 16'(breakpoint_q4(0)), 16'(breakpoint_q4(30) + 3),
			16'(breakpoint_q4(pti_pkg::ENTRIES - 1)), 16'hFFFF};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// reset value selects gold
		foreach (gold_pts[k]) send_wavelength(gold_pts[k]);
		send_wavelength(16'hAAAA);
		send_wavelength(16'h5555);
		wait_results_idle();
		write_material(32'h1234_5679);
		foreach (copper_pts[k]) send_wavelength(copper_pts[k]);
		wait_results_idle();
		write_material(32'hFFFF_FFF8);
		send_wavelength(16'(breakpoint_q4(0)));
		send_wavelength(16'hFFFF);
		wait_results_idle();
		write_material(32'h0000_0007);
		send_wavelength(16'h0000);
		send_wavelength(16'h8001);
		wait_results_idle();
	endtask

	task automatic test_random_phase(input logic [2:0] code, input int n,
			input int send_pct, input int recv_pct);
		wait_results_idle();
		write_material({29'($urandom), code});
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (n) send_wavelength(pick_wavelength());
		wait_results_idle();
	endtask

	task automatic test_unsupported_codes();
		for (int c = 0; c < 8; c++) begin
			test_random_phase(3'(c), 10, 35, 35);
		end
	endtask

	task automatic test_receiver_hold_off();
		wait_results_idle();
		write_material({29'($urandom), pti_pkg::MAT_GOLD});
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = HOLD_OFF_CYCLES;
		repeat (8) send_wavelength(pick_wavelength());
		wait_results_idle();
	endtask

	task automatic test_sender_pause();
		wait_results_idle();
		write_material({29'($urandom), pti_pkg::MAT_COPPER});
		send_idle_pct = 35;
		recv_stall_pct = 35;
		repeat (3) begin
			repeat (6) send_wavelength(pick_wavelength());
			wait_results_idle();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_request > 0) begin
			hold_left <= hold_request;
			hold_request = 0;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser[0]) bad_seen++;
			if (m_tuser[1]) sat_seen++;
			if (eps_expected.size() == 0) begin
				report_mismatch("unexpected result", 16'h0, 0, longint'($signed(m_tdata[23:0])));
			end else begin
				want = eps_expected.pop_front();
				if (m_tdata[23:0] !== want.re)
					report_mismatch("eps_real", want.wl, longint'($signed(want.re)),
						longint'($signed(m_tdata[23:0])));
				if (m_tdata[47:24] !== want.im)
					report_mismatch("eps_imag", want.wl, longint'($signed(want.im)),
						longint'($signed(m_tdata[47:24])));
				if (m_tuser[0] !== want.bad)
					report_mismatch("bad_material", want.wl, longint'(want.bad),
						longint'(m_tuser[0]));
				if (m_tuser[1] !== want.sat)
					report_mismatch("saturated", want.wl, longint'(want.sat),
						longint'(m_tuser[1]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("permittivity_table_interpolator verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_points();
		test_random_phase(pti_pkg::MAT_GOLD, 300, 0, 0);
		test_random_phase(pti_pkg::MAT_COPPER, 300, 66, 0);
		test_random_phase(pti_pkg::MAT_GOLD, 300, 0, 66);
		test_random_phase(pti_pkg::MAT_COPPER, 300, 35, 35);
		test_random_phase(pti_pkg::MAT_GOLD, 200, 35, 35);
		test_random_phase(pti_pkg::MAT_COPPER, 200, 0, 0);
		test_unsupported_codes();
		test_receiver_hold_off();
		test_sender_pause();
		wait_results_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		mismatches += eps_expected.size();
		$display("Sent %0d wavelengths, checked %0d results (%0d unsupported, %0d clipped)",
			items_sent, results_seen, bad_seen, sat_seen);
		$display("Ran gold, copper and all other codes under gaps, stalls and a %0d-cycle hold-off",
			HOLD_OFF_CYCLES);
		if (mismatches == 0) begin
			$display("permittivity_table_interpolator verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("permittivity_table_interpolator verification failed");
		end
		$finish;
	end

endmodule
